### design/sorted_list_engine_macros.svh
// Assertion macros used by the sorted list engine datapath.
`ifndef SORTED_LIST_ENGINE_MACROS_SVH
`define SORTED_LIST_ENGINE_MACROS_SVH

// Condition must hold on every clock edge outside reset.
`define SLE_ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define SLE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### design/sle_pkg.sv
// Shared types and codes for the sorted list engine.
package sle_pkg;

   typedef enum logic [1:0] {
      FUNC_INSERT  = 2'd0,
      FUNC_DEL_POS = 2'd1,
      FUNC_SEARCH  = 2'd2,
      FUNC_DEL_KEY = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      ST_OK    = 3'd0,
      ST_EMPTY = 3'd1,
      ST_RANGE = 3'd2,
      ST_NOKEY = 3'd3,
      ST_FULL  = 3'd4
   } status_type;

   localparam int VALUE_BITS = 32;
   localparam int POS_BITS   = 6;
   localparam int TOTAL_BITS = 7;

   typedef struct packed {
      logic [1:0]                   func;
      logic signed [VALUE_BITS-1:0] value;
      logic [POS_BITS-1:0]          position;
   } req_type;

   typedef struct packed {
      logic [2:0]                   status;
      logic                         found;
      logic signed [VALUE_BITS-1:0] removed_value;
      logic [TOTAL_BITS-1:0]        entry_total;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic compare;
      logic update;
   } cmd_type;

endpackage

### design/sle_ctrl.sv
// Sequencer: accept, compare, update, with a registered response valid.
module sle_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output sle_pkg::cmd_type cmd
);
   import sle_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_COMPARE,
      S_UPDATE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      req_ready   = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_COMPARE;
            end
         end
         S_COMPARE: begin
            cmd.compare = 1'b1;
            state_in    = S_UPDATE;
         end
         S_UPDATE: begin
            if (out_free) begin
               cmd.update   = 1'b1;
               rsp_valid_in = 1'b1;
               req_ready    = 1'b1;
               if (req_valid) begin
                  cmd.load = 1'b1;
                  state_in = S_COMPARE;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

### design/sle_datapath.sv
// Row of entry cells with parallel compare flags and one-step shift.
module sle_datapath #(
   parameter int CAPACITY    = 64,
   parameter int VALUE_WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  sle_pkg::cmd_type cmd,
   input  sle_pkg::req_type req_data,
   output sle_pkg::rsp_type rsp_data
);
   import sle_pkg::*;
   `include "sorted_list_engine_macros.svh"

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int PW = (CW > POS_BITS) ? CW : POS_BITS;

   logic signed [VALUE_WIDTH-1:0] cells_ff [CAPACITY];
   logic signed [VALUE_WIDTH-1:0] cells_in [CAPACITY];
   logic [CW-1:0]                 count_ff, count_in;
   logic [CAPACITY-1:0]           lt_ff, lt_in, eq_ff, eq_in, valid;
   logic signed [VALUE_WIDTH-1:0] pos_val_ff, pos_val_in;
   logic [1:0]                    func_ff;
   logic signed [VALUE_WIDTH-1:0] key_ff, key_in;
   logic [POS_BITS-1:0]           pos_ff;
   logic [PW-1:0]                 pos_ext, count_ext;
   logic [VALUE_BITS-1:0]         key_out, pos_val_out;
   rsp_type                       rsp_ff, rsp_in;
   logic                          full, empty, any_eq;
   logic                          do_ins, do_del_pos, do_del_key;

   // Input value and removed value between port width and storage width.
   generate
      if (VALUE_WIDTH <= VALUE_BITS) begin : g_narrow
         assign key_in      = req_data.value[VALUE_WIDTH-1:0];
         assign key_out     = VALUE_BITS'(unsigned'(key_ff));
         assign pos_val_out = VALUE_BITS'(unsigned'(pos_val_ff));
      end else begin : g_wide
         assign key_in      = VALUE_WIDTH'(unsigned'(req_data.value));
         assign key_out     = key_ff[VALUE_BITS-1:0];
         assign pos_val_out = pos_val_ff[VALUE_BITS-1:0];
      end
   endgenerate

   assign pos_ext   = PW'(pos_ff);
   assign count_ext = PW'(count_ff);
   assign full      = (count_ff == CW'(CAPACITY));
   assign empty     = (count_ff == '0);
   assign any_eq    = |eq_ff;

   // Per-cell compare against the key; list order makes lt a thermometer.
   always_comb begin
      pos_val_in = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         valid[i] = (CW'(i) < count_ff);
         lt_in[i] = valid[i] && (cells_ff[i] < key_ff);
         eq_in[i] = valid[i] && (cells_ff[i] == key_ff);
         if (PW'(i) == pos_ext) begin
            pos_val_in = pos_val_in | cells_ff[i];
         end
      end
   end

   always_comb begin
      rsp_in     = '0;
      do_ins     = 1'b0;
      do_del_pos = 1'b0;
      do_del_key = 1'b0;
      count_in   = count_ff;
      case (func_type'(func_ff))
         FUNC_INSERT: begin
            if (full) begin
               rsp_in.status = ST_FULL;
            end else begin
               do_ins   = 1'b1;
               count_in = count_ff + 1'b1;
            end
         end
         FUNC_DEL_POS: begin
            if (empty) begin
               rsp_in.status = ST_EMPTY;
            end else if (pos_ext >= count_ext) begin
               rsp_in.status = ST_RANGE;
            end else begin
               do_del_pos           = 1'b1;
               count_in             = count_ff - 1'b1;
               rsp_in.removed_value = pos_val_out;
            end
         end
         FUNC_SEARCH: begin
            if (any_eq) begin
               rsp_in.found = 1'b1;
            end else begin
               rsp_in.status = ST_NOKEY;
            end
         end
         FUNC_DEL_KEY: begin
            if (empty) begin
               rsp_in.status = ST_EMPTY;
            end else if (any_eq) begin
               do_del_key           = 1'b1;
               count_in             = count_ff - 1'b1;
               rsp_in.found         = 1'b1;
               rsp_in.removed_value = key_out;
            end else begin
               rsp_in.status = ST_NOKEY;
            end
         end
         default: begin
            rsp_in.status = ST_OK;
         end
      endcase
      rsp_in.entry_total = TOTAL_BITS'(count_in);
   end

   // Insert opens a slot at the first not-smaller cell; deletes close one.
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         cells_in[i] = cells_ff[i];
         if (do_ins && !lt_ff[i]) begin
            if (i == 0) begin
               cells_in[i] = key_ff;
            end else if (lt_ff[i-1]) begin
               cells_in[i] = key_ff;
            end else begin
               cells_in[i] = cells_ff[i-1];
            end
         end else if ((do_del_pos && (PW'(i) >= pos_ext)) || (do_del_key && !lt_ff[i])) begin
            if (i < CAPACITY - 1) begin
               cells_in[i] = cells_ff[i+1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         lt_ff    <= '0;
         eq_ff    <= '0;
      end else begin
         if (cmd.compare) begin
            lt_ff <= lt_in;
            eq_ff <= eq_in;
         end
         if (cmd.update) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff <= req_data.func;
         key_ff  <= key_in;
         pos_ff  <= req_data.position;
      end
      if (cmd.compare) begin
         pos_val_ff <= pos_val_in;
      end
      if (cmd.update) begin
         rsp_ff <= rsp_in;
         for (int i = 0; i < CAPACITY; i++) begin
            cells_ff[i] <= cells_in[i];
         end
      end
   end

   assign rsp_data = rsp_ff;

   `SLE_ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CW'(CAPACITY), "count over capacity")
   `SLE_ASSERT_ALWAYS(a_lt_thermo, clock, reset, ((lt_ff >> 1) & ~lt_ff) == '0, "list out of order")
   `SLE_ASSERT_ALWAYS(a_lt_eq_disjoint, clock, reset, (lt_ff & eq_ff) == '0, "flag overlap")
   `SLE_ASSERT_NEXT(a_ins_count, clock, reset, cmd.update && do_ins, count_ff == $past(count_ff) + 1'b1, "insert count")

endmodule

### design/sorted_list_engine.sv
// Sorted list engine top level: sequencer plus entry-cell datapath.
// A response is registered in the update step, which a stalled response holds.
// A new request is accepted only when idle or in the update step of the last one, so
// the compare and update passes over the entry row alternate.
// Reset clears the entry count, flags and handshake state; entry cells are not cleared.
module sorted_list_engine #(
   parameter int CAPACITY    = 64,
   parameter int VALUE_WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  sle_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output sle_pkg::rsp_type rsp_data
);
   import sle_pkg::*;

   // Command bus from sequencer to datapath:
   //   load    - capture the request transaction into the operand register
   //   compare - register per-cell less-than / equal flags and the indexed cell
   //   update  - shift the entry row, update the count, register the response
   cmd_type cmd;

   sle_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   // Entry row: each cell compares against the key in parallel; as the row stays
   // ascending, the flags steer insert and key-delete shifts but not position deletes.
   sle_datapath #(
      .CAPACITY    (CAPACITY),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

endmodule
